FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

`endif

FILE: hdl/dwwf_pkg.sv
// Types and constants of the display window write framer.
package dwwf_pkg;

    localparam int COORD_BITS = 9;
    localparam int LEFT_W     = 19;
    localparam logic [LEFT_W-1:0] LEFT_MAX = {LEFT_W{1'b1}};
    localparam int PROD_W     = (2 * (COORD_BITS + 1) > LEFT_W) ?
                                2 * (COORD_BITS + 1) : LEFT_W;

    localparam int WIN_BYTES  = 11;
    localparam int IDX_W      = $clog2(WIN_BYTES);

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] CMD_COL = 8'h2A;
    localparam logic [7:0] CMD_ROW = 8'h2B;
    localparam logic [7:0] CMD_MEM = 8'h2C;

    localparam logic OP_WINDOW = 1'b0;
    localparam logic OP_PIXEL  = 1'b1;

    typedef enum logic [1:0] {
        K_WIN  = 2'd0,
        K_PIX  = 2'd1,
        K_DROP = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] ye;
        logic [15:0]           color;
        logic                  rel_lo;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic full;
    } t_qwr;

    typedef struct packed {
        logic pop;
        logic nempty;
    } t_qrd;

endpackage

FILE: hdl/dwwf_queue.sv
// Short command queue between the front and the back.
module dwwf_queue import dwwf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_wdata,
    input  logic i_pop,
    output logic o_full,
    output logic o_nempty,
    output t_cmd o_head
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full   = (r_cnt == QCNT_W'(QDEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_head   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: hdl/dwwf_front.sv
// Front: accepts words, tracks the window pixel count, queues commands.
module dwwf_front import dwwf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_opcode,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [15:0]           i_pixel_color,
    input  logic                  i_qfull,
    output t_qwr                  o_qwr,
    output t_cmd                  o_cmd
);

    logic [LEFT_W-1:0]   r_left;
    logic [LEFT_W-1:0]   n_left;
    logic [COORD_BITS:0] dx;
    logic [COORD_BITS:0] dy;
    logic [PROD_W-1:0]   prod;
    logic                rev;
    logic                acc;

    assign o_stall    = i_qfull;
    assign acc        = i_valid && !i_qfull;
    assign o_qwr.push = acc;
    assign o_qwr.full = i_qfull;

    always_comb begin
        dx   = {1'b0, i_x_end} - {1'b0, i_x_start} + 1'b1;
        dy   = {1'b0, i_y_end} - {1'b0, i_y_start} + 1'b1;
        rev  = (i_x_end < i_x_start) || (i_y_end < i_y_start);
        prod = PROD_W'(dx) * PROD_W'(dy);

        o_cmd.xs     = i_x_start;
        o_cmd.xe     = i_x_end;
        o_cmd.ys     = i_y_start;
        o_cmd.ye     = i_y_end;
        o_cmd.color  = i_pixel_color;
        o_cmd.rel_lo = 1'b0;
        n_left       = r_left;

        if (i_opcode == OP_WINDOW) begin
            o_cmd.kind = K_WIN;
            if (rev) begin
                n_left = '0;
            end else if (prod > PROD_W'(LEFT_MAX)) begin
                n_left = LEFT_MAX;
            end else begin
                n_left = prod[LEFT_W-1:0];
            end
        end else if (r_left == '0) begin
            o_cmd.kind = K_DROP;
        end else begin
            o_cmd.kind   = K_PIX;
            o_cmd.rel_lo = (r_left == LEFT_W'(1));
            n_left       = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (acc) begin
            r_left <= n_left;
        end
    end

endmodule

FILE: hdl/dwwf_back.sv
// Back: serializes queued commands into output bytes.
module dwwf_back import dwwf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_qnempty,
    input  t_cmd       i_head,
    output t_qrd       o_qrd,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_select_release,
    output logic       o_overflow,
    output logic       o_last
);

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_data;
    logic             r_rel;
    logic             r_ovf;
    logic             r_last;

    logic [7:0]  b;
    logic        d;
    logic        rl;
    logic        ov;
    logic        fin;
    logic        load;
    logic [15:0] xs16;
    logic [15:0] xe16;
    logic [15:0] ys16;
    logic [15:0] ye16;

    assign load         = i_qnempty && (!r_valid || !i_stall);
    assign o_qrd.pop    = load && fin;
    assign o_qrd.nempty = i_qnempty;

    always_comb begin
        xs16 = 16'(i_head.xs);
        xe16 = 16'(i_head.xe);
        ys16 = 16'(i_head.ys);
        ye16 = 16'(i_head.ye);
        b    = '0;
        d    = 1'b1;
        rl   = 1'b0;
        ov   = 1'b0;
        fin  = 1'b0;
        unique case (i_head.kind)
            K_WIN: begin
                unique case (r_idx)
                    IDX_W'(0):  begin b = CMD_COL;    d = 1'b0; rl = 1'b1; end
                    IDX_W'(1):  begin b = xs16[15:8]; end
                    IDX_W'(2):  begin b = xs16[7:0];  rl = 1'b1; end
                    IDX_W'(3):  begin b = xe16[15:8]; end
                    IDX_W'(4):  begin b = xe16[7:0];  rl = 1'b1; end
                    IDX_W'(5):  begin b = CMD_ROW;    d = 1'b0; rl = 1'b1; end
                    IDX_W'(6):  begin b = ys16[15:8]; end
                    IDX_W'(7):  begin b = ys16[7:0];  rl = 1'b1; end
                    IDX_W'(8):  begin b = ye16[15:8]; end
                    IDX_W'(9):  begin b = ye16[7:0];  rl = 1'b1; end
                    default: begin
                        b = CMD_MEM; d = 1'b0; rl = 1'b1; fin = 1'b1;
                    end
                endcase
            end
            K_PIX: begin
                if (r_idx == '0) begin
                    b = i_head.color[15:8];
                end else begin
                    b   = i_head.color[7:0];
                    rl  = i_head.rel_lo;
                    fin = 1'b1;
                end
            end
            default: begin
                d   = 1'b0;
                ov  = 1'b1;
                fin = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= fin ? '0 : r_idx + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= b;
            r_data <= d;
            r_rel  <= rl;
            r_ovf  <= ov;
            r_last <= fin;
        end
    end

    assign o_valid          = r_valid;
    assign o_out_byte       = r_byte;
    assign o_is_data        = r_data;
    assign o_select_release = r_rel;
    assign o_overflow       = r_ovf;
    assign o_last           = r_last;

endmodule

FILE: hdl/display_window_write_framer.sv
// Top level of the display window write framer.
//
// Input channel (i_valid / o_stall): one word is either an open-window
// request (opcode 0, with start and end column and row) or one pixel
// (opcode 1, RGB565). A window word produces 11 output bytes: the column
// command with start/end column, the row command with start/end row, and
// the memory-write command. A pixel word produces two data bytes, high
// byte first; a pixel beyond the window count produces one byte flagged
// overflow. o_last marks the final byte of each input word.
// Output channel (o_valid / i_stall): one byte per transfer, with its
// data/command level and a chip-select release mark.
// An accepted word is registered in the command queue; its first byte is
// then loaded from the queue head into the output register. The serializer
// gives one byte per cycle while the receiver does not stall; a 2-entry
// command queue lets the input keep taking words while the serializer works.
// Reset clears the pixel count, the queue pointers and count, and the output valid flag and byte index.
// While the receiver stalls the output byte holds; once the queue fills,
// o_stall rises.
module display_window_write_framer import dwwf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_opcode,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [15:0]           i_pixel_color,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_is_data,
    output logic                  o_select_release,
    output logic                  o_overflow,
    output logic                  o_last
);

    t_qwr qwr;
    t_qrd qrd;
    t_cmd wcmd;
    t_cmd head;
    logic qfull;
    logic qnempty;

    dwwf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_pixel_color (i_pixel_color),
        .i_qfull       (qfull),
        .o_qwr         (qwr),
        .o_cmd         (wcmd)
    );

    dwwf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (qwr.push),
        .i_wdata  (wcmd),
        .i_pop    (qrd.pop),
        .o_full   (qfull),
        .o_nempty (qnempty),
        .o_head   (head)
    );

    dwwf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_qnempty        (qnempty),
        .i_head           (head),
        .o_qrd            (qrd),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_is_data        (o_is_data),
        .o_select_release (o_select_release),
        .o_overflow       (o_overflow),
        .o_last           (o_last)
    );

endmodule

FILE: hdl/dwwf_checker.sv
// Port-level checks of the display window write framer, with bind.
`include "assert_macros.svh"

module dwwf_checker import dwwf_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_is_data,
    input logic       o_select_release,
    input logic       o_overflow,
    input logic       o_last
);

    logic ov_ok;
    logic mem_last;

    assign ov_ok    = o_last && !o_is_data && !o_select_release && (o_out_byte == 8'h00);
    assign mem_last = o_valid && o_last && !o_overflow && !o_is_data;

    `ASSERT_IMP(a_ovf_shape, i_clk, i_rst_n, o_valid && o_overflow, ov_ok)
    `ASSERT_IMP(a_cmd_release, i_clk, i_rst_n, o_valid && !o_is_data && !o_overflow, o_select_release)
    `ASSERT_IMP(a_mem_last, i_clk, i_rst_n, mem_last, o_out_byte == CMD_MEM)
    `ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_byte))

endmodule

bind display_window_write_framer dwwf_checker u_dwwf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_out_byte       (o_out_byte),
    .o_is_data        (o_is_data),
    .o_select_release (o_select_release),
    .o_overflow       (o_overflow),
    .o_last           (o_last)
);

FILE: tb/display_window_write_framer_test.sv
// Self-checking testbench for the display window write framer.
module display_window_write_framer_test;
    import dwwf_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RAND_WORDS  = 100;

    typedef struct {
        logic                  op;
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ye;
        logic [15:0]           color;
    } t_word;

    typedef struct {
        logic [7:0] val;
        logic       data;
        logic       rel;
        logic       ovf;
        logic       fin;
    } t_frame_byte;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  i_opcode      = 1'b0;
    logic [COORD_BITS-1:0] i_x_start     = '0;
    logic [COORD_BITS-1:0] i_y_start     = '0;
    logic [COORD_BITS-1:0] i_x_end       = '0;
    logic [COORD_BITS-1:0] i_y_end       = '0;
    logic [15:0]           i_pixel_color = '0;
    logic                  i_stall       = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [7:0]            o_out_byte;
    logic                  o_is_data;
    logic                  o_select_release;
    logic                  o_overflow;
    logic                  o_last;

    display_window_write_framer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_x_start        (i_x_start),
        .i_y_start        (i_y_start),
        .i_x_end          (i_x_end),
        .i_y_end          (i_y_end),
        .i_pixel_color    (i_pixel_color),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_is_data        (o_is_data),
        .o_select_release (o_select_release),
        .o_overflow       (o_overflow),
        .o_last           (o_last)
    );

    t_word             pending_words[$];
    t_frame_byte       bytes_due[$];
    logic [LEFT_W-1:0] pix_remaining = '0;
    t_word             cur_word;
    logic              word_taken    = 1'b0;
    int                gap_left      = 0;
    int                calm_left     = 0;
    int                hold_left     = 0;
    logic              hold_done     = 1'b0;
    int                busy_left     = 0;
    int                free_left     = 0;
    int                words_in      = 0;
    int                cycles        = 0;
    int                errors        = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    task push_byte(input logic [7:0] val, input logic data, input logic rel,
                   input logic ovf, input logic fin);
        t_frame_byte b;
        b.val  = val;
        b.data = data;
        b.rel  = rel;
        b.ovf  = ovf;
        b.fin  = fin;
        bytes_due.push_back(b);
    endtask

    task push_pair(input logic [15:0] v, input logic rel_lo, input logic fin);
        push_byte(v[15:8], 1'b1, 1'b0, 1'b0, 1'b0);
        push_byte(v[7:0], 1'b1, rel_lo, 1'b0, fin);
    endtask

    task frame_word(input t_word w);
        longint dx, dy, n;
        if (w.op == OP_WINDOW) begin
            n = 0;
            if (w.xe >= w.xs && w.ye >= w.ys) begin
                dx = longint'(w.xe) - longint'(w.xs) + 1;
                dy = longint'(w.ye) - longint'(w.ys) + 1;
                n  = dx * dy;
                if (n > longint'(LEFT_MAX)) n = longint'(LEFT_MAX);
            end
            pix_remaining = n[LEFT_W-1:0];
            push_byte(CMD_COL, 1'b0, 1'b1, 1'b0, 1'b0);
            push_pair(16'(w.xs), 1'b1, 1'b0);
            push_pair(16'(w.xe), 1'b1, 1'b0);
            push_byte(CMD_ROW, 1'b0, 1'b1, 1'b0, 1'b0);
            push_pair(16'(w.ys), 1'b1, 1'b0);
            push_pair(16'(w.ye), 1'b1, 1'b0);
            push_byte(CMD_MEM, 1'b0, 1'b1, 1'b0, 1'b1);
        end else if (pix_remaining == '0) begin
            push_byte(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        end else begin
            pix_remaining = pix_remaining - 1'b1;
            push_pair(w.color, pix_remaining == '0, 1'b1);
        end
    endtask

    task check_byte;
        t_frame_byte e;
        if (bytes_due.size() == 0) begin
            report("byte with nothing due", 32'(o_out_byte), 0);
        end else begin
            e = bytes_due.pop_front();
            if (o_out_byte !== e.val) report("out_byte", 32'(o_out_byte), 32'(e.val));
            if (o_is_data !== e.data) report("is_data", 32'(o_is_data), 32'(e.data));
            if (o_select_release !== e.rel)
                report("select_release", 32'(o_select_release), 32'(e.rel));
            if (o_overflow !== e.ovf) report("overflow", 32'(o_overflow), 32'(e.ovf));
            if (o_last !== e.fin) report("last", 32'(o_last), 32'(e.fin));
        end
    endtask

    task add_window(input int xs, input int ys, input int xe, input int ye);
        t_word w;
        w.op    = OP_WINDOW;
        w.xs    = COORD_BITS'(xs);
        w.ys    = COORD_BITS'(ys);
        w.xe    = COORD_BITS'(xe);
        w.ye    = COORD_BITS'(ye);
        w.color = 16'($urandom);
        pending_words.push_back(w);
    endtask

    task add_pixel(input logic [15:0] color);
        t_word w;
        w.op    = OP_PIXEL;
        w.xs    = COORD_BITS'($urandom);
        w.ys    = COORD_BITS'($urandom);
        w.xe    = COORD_BITS'($urandom);
        w.ye    = COORD_BITS'($urandom);
        w.color = color;
        pending_words.push_back(w);
    endtask

    function int gap_len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 9);
        return $urandom_range(16, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles     <= cycles + 1;
        word_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                frame_word('{i_opcode, i_x_start, i_y_start, i_x_end, i_y_end,
                             i_pixel_color});
                words_in <= words_in + 1;
            end
            if (o_valid && !i_stall) check_byte();
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !word_taken)) begin
            if (gap_left > 0) begin
                i_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_words.size() > 0) begin
                cur_word       = pending_words.pop_front();
                i_valid       <= 1'b1;
                i_opcode      <= cur_word.op;
                i_x_start     <= cur_word.xs;
                i_y_start     <= cur_word.ys;
                i_x_end       <= cur_word.xe;
                i_y_end       <= cur_word.ye;
                i_pixel_color <= cur_word.color;
                if (calm_left > 0) begin
                    calm_left <= calm_left - 1;
                    gap_left  <= 0;
                end else if ($urandom_range(0, 14) == 0) begin
                    calm_left <= $urandom_range(8, 20);
                    gap_left  <= 0;
                end else begin
                    gap_left <= gap_len();
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure; one long hold-off to fill the block
    always @(negedge i_clk) begin
        if (!hold_done && words_in >= 30) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (busy_left > 0) begin
            busy_left <= busy_left - 1;
            i_stall   <= 1'b1;
        end else if (free_left > 0) begin
            free_left <= free_left - 1;
            i_stall   <= 1'b0;
        end else begin
            free_left <= $urandom_range(0, 24);
            busy_left <= gap_len();
            i_stall   <= 1'b0;
        end
    end

    initial begin
        int n_rand, kind, w, h, xs, ys, cnt, extra;

        // directed words
        add_pixel(16'h1234);
        add_window(0, 0, 511, 511);
        add_pixel(16'h0000);
        add_pixel(16'hFFFF);
        add_window(511, 0, 0, 0);
        add_pixel(16'hAAAA);
        add_window(0, 10, 0, 5);
        add_pixel(16'h5555);
        add_window(511, 511, 511, 511);
        add_pixel(16'hFFFF);
        add_pixel(16'h0000);
        add_window(255, 256, 256, 256);
        add_pixel(16'hA5A5);
        add_pixel(16'h5A5A);
        add_window(3, 7, 3, 8);
        add_pixel(16'h8001);
        add_window(256, 255, 256, 255);
        add_pixel(16'h7FFE);
        add_pixel(16'h00FF);

        n_rand = 0;
        while (n_rand < RAND_WORDS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                w  = $urandom_range(1, 4);
                h  = $urandom_range(1, 4);
                xs = $urandom_range(0, 512 - w);
                ys = $urandom_range(0, 512 - h);
                add_window(xs, ys, xs + w - 1, ys + h - 1);
                cnt   = w * h;
                extra = $urandom_range(0, 9);
                if (extra == 7) cnt = $urandom_range(0, cnt - 1);
                else if (extra >= 8) cnt = cnt + $urandom_range(1, 2);
                repeat (cnt) add_pixel(16'($urandom));
                n_rand += cnt + 1;
            end else if (kind == 7) begin
                add_window($urandom_range(0, 511), $urandom_range(0, 511),
                           $urandom_range(0, 511), $urandom_range(0, 511));
                cnt = $urandom_range(0, 3);
                repeat (cnt) add_pixel(16'($urandom));
                n_rand += cnt + 1;
            end else if (kind == 8) begin
                xs = $urandom_range(1, 511);
                add_window(xs, $urandom_range(0, 511), xs - 1, $urandom_range(0, 511));
                add_pixel(16'($urandom));
                n_rand += 2;
            end else begin
                add_pixel(16'($urandom));
                n_rand += 1;
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_valid || bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (bytes_due.size() != 0) report("bytes never sent", bytes_due.size(), 0);

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
